[rtl/sqs_pkg.sv]
`timescale 1ns / 1ps

package sqs_pkg;

  // Width of the input port, and the bits of it that carry the value
  localparam int RADICAND_W    = 32;
  localparam int RADICAND_BITS = 32;
  localparam int VAL_W         = RADICAND_BITS - 1;
  localparam int ROOT_W        = (VAL_W + 1) / 2;
  localparam int SQ_W          = 2 * ROOT_W;
  localparam int CNT_W         = $clog2(VAL_W);
  localparam int COEF_W        = 16;
  localparam int SFP_W         = 31;

  // Top bit of the root search, an even bit position
  localparam logic [SQ_W-1:0] SQRT_BIT_TOP = SQ_W'(1) << (SQ_W - 2);
  localparam logic [CNT_W-1:0] SQRT_STEPS_M1 = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_STEPS_M1  = CNT_W'(VAL_W - 1);

  // Controller states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SQRT  = 8'b0000_0010,
    ST_CAND  = 8'b0000_0100,
    ST_TEST  = 8'b0000_1000,
    ST_SQ    = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_CHECK = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } sqs_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic cand_load;
    logic sq_load;
    logic div_step;
    logic found;
    logic cand_dec;
    logic out_load;
  } sqs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;
    logic cnt_zero;
    logic cand_gt1;
    logic rem_zero;
  } sqs_status_t;

endpackage

[rtl/square_root_simplifier_unit.sv]
// Square root simplifier: writes sqrt(radicand) as coefficient * sqrt(square_free_part).
// Input channel: in_valid_i / in_stall_o with radicand_i; a transaction completes on a
// rising edge with valid high and stall low. in_stall_o is high while an item is at work.
// Output channel: out_valid_o / out_stall_i with coefficient_o, square_free_part_o and
// negative_error_o, held in an output register that keeps its value while stalled.
// One result per input. Negative input: negative_error_o = 1, other fields zero.
// Zero input: coefficient 0, square-free part 1.
// Timing: integer square root first (two bits per cycle), then for each candidate
// k tried, from the root downward: a test, a step that squares k, the bit-serial
// remainder of value / (k*k), and a check. The first k that divides ends the
// search. The worst case is about 46339 candidates; special values skip the
// search. The divider sets the rate.
// The next item is accepted once the result is in the output register, even while
// the receiver still stalls; a further result waits until that register is taken.
// Reset (rst_ni, asynchronous, active low) returns to idle with no result pending.
`timescale 1ns / 1ps

module square_root_simplifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sqs_pkg::RADICAND_W-1:0] radicand_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sqs_pkg::COEF_W-1:0]     coefficient_o,
  output logic [sqs_pkg::SFP_W-1:0]      square_free_part_o,
  output logic                           negative_error_o
);
  import sqs_pkg::*;

  sqs_cmd_t    cmd;
  sqs_status_t status;

  sqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sqs_dp u_dp (
    .clk_i             (clk_i),
    .radicand_i        (radicand_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .coefficient_o     (coefficient_o),
    .square_free_part_o(square_free_part_o),
    .negative_error_o  (negative_error_o)
  );

endmodule

[rtl/sqs_ctrl.sv]
`timescale 1ns / 1ps

module sqs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  sqs_pkg::sqs_status_t status_i,
  output sqs_pkg::sqs_cmd_t    cmd_o
);
  import sqs_pkg::*;

  sqs_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (status_i.special) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.sqrt_step = 1'b1;
          if (status_i.cnt_zero) state_d = ST_CAND;
        end
      end
      ST_CAND: begin
        cmd_o.cand_load = 1'b1;
        state_d         = ST_TEST;
      end
      ST_TEST: begin
        state_d = status_i.cand_gt1 ? ST_SQ : ST_DONE;
      end
      ST_SQ: begin
        cmd_o.sq_load = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.cnt_zero) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (status_i.rem_zero) begin
          cmd_o.found = 1'b1;
          state_d     = ST_DONE;
        end else begin
          cmd_o.cand_dec = 1'b1;
          state_d        = ST_TEST;
        end
      end
      ST_DONE: begin
        // output register free, or its transaction completes now
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Checks
  a_accept_starts_sqrt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> state_q == ST_SQRT)
    else $error("accepted transaction did not start root search");

  a_valid_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result valid raised outside done state");

  a_check_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK |-> $past(state_q == ST_DIV))
    else $error("remainder checked before division finished");

endmodule

[rtl/sqs_dp.sv]
`timescale 1ns / 1ps

module sqs_dp (
  input  logic                           clk_i,
  input  logic [sqs_pkg::RADICAND_W-1:0] radicand_i,
  input  sqs_pkg::sqs_cmd_t              cmd_i,
  output sqs_pkg::sqs_status_t           status_o,
  output logic [sqs_pkg::COEF_W-1:0]     coefficient_o,
  output logic [sqs_pkg::SFP_W-1:0]      square_free_part_o,
  output logic                           negative_error_o
);
  import sqs_pkg::*;

  logic [VAL_W-1:0]  v_q;
  logic              neg_q, zero_q;
  logic [SQ_W-1:0]   srem_q, res_q, bit_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ROOT_W-1:0] cand_q;
  logic [SQ_W-1:0]   sq_q, drem_q;
  logic [VAL_W-1:0]  dvd_q;
  logic [ROOT_W-1:0] k_q;
  logic [VAL_W-1:0]  m_q;
  logic [COEF_W-1:0] coef_q;
  logic [SFP_W-1:0]  sfp_q;
  logic              err_q;

  logic [VAL_W-1:0]  v_in;
  logic [SQ_W-1:0]   sqrt_trial;
  logic              sqrt_ge;
  logic [SQ_W:0]     div_trial, div_sub;
  logic              div_ge;

  assign v_in = radicand_i[VAL_W-1:0];

  // Root search step: two bits per cycle
  assign sqrt_trial = res_q + bit_q;
  assign sqrt_ge    = (srem_q >= sqrt_trial);

  // Restoring division step: one quotient bit per cycle
  assign div_trial = {drem_q, dvd_q[VAL_W-1]};
  assign div_sub   = div_trial - {1'b0, sq_q};
  assign div_ge    = (div_trial >= {1'b0, sq_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q    <= v_in;
      neg_q  <= radicand_i[RADICAND_BITS-1];
      zero_q <= (v_in == '0);
      srem_q <= SQ_W'(v_in);
      res_q  <= '0;
      bit_q  <= SQRT_BIT_TOP;
      cnt_q  <= SQRT_STEPS_M1;
      k_q    <= ROOT_W'(1);
      m_q    <= v_in;
    end
    if (cmd_i.sqrt_step) begin
      if (sqrt_ge) begin
        srem_q <= srem_q - sqrt_trial;
        res_q  <= (res_q >> 1) + bit_q;
      end else begin
        res_q  <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.cand_load) cand_q <= res_q[ROOT_W-1:0];
    // square of the candidate, then clear the divider
    if (cmd_i.sq_load) begin
      sq_q   <= SQ_W'(cand_q) * SQ_W'(cand_q);
      drem_q <= '0;
      dvd_q  <= v_q;
      cnt_q  <= DIV_STEPS_M1;
    end
    if (cmd_i.div_step) begin
      drem_q <= div_ge ? div_sub[SQ_W-1:0] : div_trial[SQ_W-1:0];
      dvd_q  <= {dvd_q[VAL_W-2:0], div_ge};
      cnt_q  <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.found) begin
      k_q <= cand_q;
      m_q <= dvd_q;
    end
    if (cmd_i.cand_dec) cand_q <= cand_q - ROOT_W'(1);
    // result register
    if (cmd_i.out_load) begin
      err_q <= neg_q;
      if (neg_q) begin
        coef_q <= '0;
        sfp_q  <= '0;
      end else if (zero_q) begin
        coef_q <= '0;
        sfp_q  <= SFP_W'(1);
      end else begin
        coef_q <= COEF_W'(k_q);
        sfp_q  <= SFP_W'(m_q);
      end
    end
  end

  assign status_o.special  = neg_q | zero_q;
  assign status_o.cnt_zero = (cnt_q == '0);
  assign status_o.cand_gt1 = (cand_q > ROOT_W'(1));
  assign status_o.rem_zero = (drem_q == '0);

  assign coefficient_o      = coef_q;
  assign square_free_part_o = sfp_q;
  assign negative_error_o   = err_q;

endmodule

[bench/square_root_simplifier_unit_tb.sv]
`timescale 1ns / 1ps

module square_root_simplifier_unit_tb;
  import sqs_pkg::*;

  // One simplified root: coefficient * sqrt(square-free part), or a sign error
  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic [SFP_W-1:0]  sfp;
    logic              neg;
  } root_form_t;

  // Directed row: value, and a hand-written result where one is given
  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
    logic                  typed;
    root_form_t            want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 100;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic [RADICAND_W-1:0] radicand_i  = '0;
  logic                  out_stall_i = 1'b1;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic [COEF_W-1:0]     coefficient_o;
  logic [SFP_W-1:0]      square_free_part_o;
  logic                  negative_error_o;

  root_form_t pending_roots [$];
  stim_row_t  directed_rows [$];
  int         mismatch_count = 0;
  bit         no_idle = 1'b0;

  square_root_simplifier_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .radicand_i         (radicand_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .coefficient_o      (coefficient_o),
    .square_free_part_o (square_free_part_o),
    .negative_error_o   (negative_error_o)
  );

  always #1 clk_i = ~clk_i;

  // Largest square divisor: exact integer root, then search down for k*k | v
  function automatic root_form_t simplify_root(input logic [RADICAND_W-1:0] x);
    longint unsigned raw;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned sq;
    root_form_t      r;
    raw = 64'(x) & ((64'd1 << RADICAND_BITS) - 64'd1);
    r = '0;
    if (((raw >> (RADICAND_BITS - 1)) & 64'd1) != 0) begin
      r.neg = 1'b1;
      return r;
    end
    if (raw == 0) begin
      r.sfp = SFP_W'(1);
      return r;
    end
    // bitwise root, MSB first
    root = 0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= raw) root = trial;
    end
    r.coef = COEF_W'(1);
    r.sfp  = SFP_W'(raw);
    for (longint unsigned c = root; c > 1; c--) begin
      sq = c * c;
      if (raw % sq == 0) begin
        r.coef = COEF_W'(c);
        r.sfp  = SFP_W'(raw / sq);
        break;
      end
    end
    return r;
  endfunction

  function automatic stim_row_t row(input logic [RADICAND_W-1:0] v, input bit typed,
                                    input int coef, input int sfp, input bit neg);
    return {v, typed, COEF_W'(coef), SFP_W'(sfp), neg};
  endfunction

  // Random value; kept to shapes whose search ends quickly
  function automatic logic [RADICAND_W-1:0] random_radicand();
    logic [31:0] k;
    logic [31:0] m;
    case ($urandom_range(0, 3))
      0: return {1'b1, 31'($urandom)};
      1: return RADICAND_W'($urandom_range(1, 4095));
      2: begin
        // perfect square, any size: found on the first candidate
        k = $urandom_range(2, 46340);
        return RADICAND_W'(k * k);
      end
      default: begin
        // small k with a small cofactor: short search
        k = $urandom_range(2, 64);
        m = $urandom_range(1, 15);
        return RADICAND_W'(k * k * m);
      end
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Input side: random gap, then hold the transaction until accepted
  task automatic send_radicand(input logic [RADICAND_W-1:0] v, input logic typed,
                               input root_form_t typed_want);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    radicand_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    pending_roots.push_back(typed ? typed_want : simplify_root(v));
  endtask

  // Output side: random stall per transaction, then compare with oldest expectation
  initial begin
    int         w;
    root_form_t want;
    @(posedge rst_ni);
    forever begin
      w = no_idle ? 0 : $urandom_range(0, 4);
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_roots.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: k=%0d m=%0d neg=%0b",
                                  coefficient_o, square_free_part_o, negative_error_o));
      end else begin
        want = pending_roots.pop_front();
        if (coefficient_o !== want.coef)
          report_mismatch($sformatf("coefficient %0d, expected %0d",
                                    coefficient_o, want.coef));
        if (square_free_part_o !== want.sfp)
          report_mismatch($sformatf("square_free_part %0d, expected %0d",
                                    square_free_part_o, want.sfp));
        if (negative_error_o !== want.neg)
          report_mismatch($sformatf("negative_error %0b, expected %0b",
                                    negative_error_o, want.neg));
      end
    end
  end

  // Stimulus: directed table, then random values
  initial begin
    // zero, the small values, squares, mixed factors, negatives
    directed_rows.push_back(row(32'd0,          1, 0,     1,   0));
    directed_rows.push_back(row(32'd1,          1, 1,     1,   0));
    directed_rows.push_back(row(32'd2,          1, 1,     2,   0));
    directed_rows.push_back(row(32'd3,          1, 1,     3,   0));
    directed_rows.push_back(row(32'd4,          1, 2,     1,   0));
    directed_rows.push_back(row(32'd5,          0, 0,     0,   0));
    directed_rows.push_back(row(32'd8,          0, 0,     0,   0));
    directed_rows.push_back(row(32'd12,         0, 0,     0,   0));
    directed_rows.push_back(row(32'd50,         0, 0,     0,   0));
    directed_rows.push_back(row(32'd72,         0, 0,     0,   0));
    directed_rows.push_back(row(32'd97,         0, 0,     0,   0));
    directed_rows.push_back(row(32'd360,        0, 0,     0,   0));
    directed_rows.push_back(row(32'd1024,       1, 32,    1,   0));
    directed_rows.push_back(row(32'd3600,       1, 60,    1,   0));
    directed_rows.push_back(row(32'd1000000,    1, 1000,  1,   0));
    directed_rows.push_back(row(32'd2000000,    0, 0,     0,   0));
    directed_rows.push_back(row(32'd1073741824, 1, 32768, 1,   0));
    // largest square in range; a prime near the top would take the full search
    directed_rows.push_back(row(32'd2147395600, 1, 46340, 1,   0));
    directed_rows.push_back(row(32'hFFFF_FFFF,  1, 0,     0,   1));
    directed_rows.push_back(row(32'h8000_0000,  1, 0,     0,   1));
    directed_rows.push_back(row(32'h8000_0001,  1, 0,     0,   1));
    directed_rows.push_back(row(32'hAAAA_5555,  1, 0,     0,   1));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_radicand(directed_rows[i].radicand, directed_rows[i].typed, directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // a stretch with no idling on either side
      no_idle = (n >= 40 && n < 60);
      send_radicand(random_radicand(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk_i);
    // catch any extra result
    repeat (8000) @(posedge clk_i);

    if (mismatch_count == 0)
      $display("square_root_simplifier_unit test passed");
    else
      $display("square_root_simplifier_unit test failed");
    $finish;
  end

  // Watchdog
  initial begin
    #8_000_000;
    $display("square_root_simplifier_unit test failed");
    $finish;
  end

endmodule

[square_root_simplifier_unit.f]
rtl/sqs_pkg.sv
rtl/sqs_ctrl.sv
rtl/sqs_dp.sv
rtl/square_root_simplifier_unit.sv
bench/square_root_simplifier_unit_tb.sv
